/* rtl/smpn_pkg.sv */
// Shared types and constants for the stereo mix peak normalizer.
package smpn_pkg;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  // Operation selector carried in the input tuser
  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_GAIN    = 2'd1,
    OP_MIX     = 2'd2,
    OP_CLEAR   = 2'd3
  } smpn_op_t;

  // Result kind carried in the output tuser
  localparam logic KIND_MIX  = 1'b0;
  localparam logic KIND_GAIN = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;       // capture an accepted item
    logic exec;        // run a measure, mix or clear item
    logic div_start;   // launch one gain division
    logic div_lo;      // division uses the low peak
    logic cand_store;  // keep the high-peak quotient
    logic gain_load;   // commit the new gain and report it
  } smpn_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // output register empty or draining
    logic div_done;    // quotient ready
  } smpn_stat_t;

endpackage

/* rtl/stereo_mix_peak_normalizer.sv */
// Top level of the stereo mix peak normalizer.
// Measure, mix and clear items are captured (with the scaling multiply), then executed;
// a frame result is valid the cycle after execute; a waiting result stalls s_tready.
// Compute-gain runs two bit-serial divisions of 16+GAIN_FRAC_BITS quotient bits each, high
// peak then low peak, and takes no new item until the new gain is loaded and reported.
// Synchronous active-high rst zeroes sums and peaks, sets unity gain, drops m_tvalid;
// s_tready is high from the first cycle after reset drops.
module stereo_mix_peak_normalizer #(
  parameter int MAX_TRACKS     = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // left_sample[15:0], right_sample[31:16]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  input  logic        s_tlast,   // last_track
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_out, right_out, gain_value (GAIN_FRAC_BITS+1), normalized, zero pad
  output logic [((GAIN_FRAC_BITS + 34 + 7) / 8) * 8 - 1:0] m_tdata,
  output logic [0:0]  m_tuser    // kind[0]
);

  import smpn_pkg::*;

  localparam int OUT_W = ((GAIN_FRAC_BITS + 34 + 7) / 8) * 8;

  smpn_cmd_t                cmd;
  smpn_stat_t               stat;
  smpn_op_t                 op;
  logic                     out_kind;
  logic                     out_norm;
  logic signed [15:0]       out_left, out_right;
  logic [GAIN_FRAC_BITS:0]  out_gain;

  assign op = smpn_op_t'(s_tuser);

  // Sequencer: item capture/execute and the two-step gain division
  smpn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .s_valid(s_tvalid),
    .op     (op),
    .stat   (stat),
    .s_ready(s_tready),
    .cmd    (cmd)
  );

  // Arithmetic, state and the output register
  smpn_dp #(
    .MAX_TRACKS    (MAX_TRACKS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .op_in    (op),
    .left_in  (s_tdata[15:0]),
    .right_in (s_tdata[31:16]),
    .last_in  (s_tlast),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_kind (out_kind),
    .out_left (out_left),
    .out_right(out_right),
    .out_gain (out_gain),
    .out_norm (out_norm)
  );

  // Pack the result, upper pad bits zero
  assign m_tdata    = OUT_W'({out_norm, out_gain, out_right, out_left});
  assign m_tuser[0] = out_kind;

endmodule

/* rtl/smpn_div.sv */
// Restoring divider, one quotient bit per cycle.
module smpn_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [DEN_W:0]   trial;

  // quo doubles as the dividend shift register
  assign trial = {rem, quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
        rem     <= '0;
        quo     <= num;
        divisor <= den;
      end else if (busy) begin
        // zero divisor yields all ones, above any gain limit
        if (trial >= {1'b0, divisor}) begin
          rem <= DEN_W'(trial - {1'b0, divisor});
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

/* rtl/smpn_dp.sv */
// Datapath: scaling, frame sums, peaks, gain and output register.
module smpn_dp #(
  parameter int MAX_TRACKS     = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  smpn_pkg::smpn_cmd_t      cmd,
  output smpn_pkg::smpn_stat_t     stat,
  input  smpn_pkg::smpn_op_t       op_in,
  input  logic signed [15:0]       left_in,
  input  logic signed [15:0]       right_in,
  input  logic                     last_in,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     out_kind,
  output logic signed [15:0]       out_left,
  output logic signed [15:0]       out_right,
  output logic [GAIN_FRAC_BITS:0]  out_gain,
  output logic                     out_norm
);

  import smpn_pkg::*;

  localparam int ACC_W  = $clog2(MAX_TRACKS) + 16;
  localparam int SUM_W  = ACC_W + 2;
  localparam int GAIN_W = GAIN_FRAC_BITS + 1;
  localparam int PROD_W = 16 + GAIN_W;
  localparam int NUM_W  = 16 + GAIN_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(MAX_TRACKS * 32768 - 1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'(-MAX_TRACKS * 32768);
  localparam logic [GAIN_W-1:0]       UNITY   = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [NUM_W-1:0]        NUM_HI  = NUM_W'(SAMPLE_MAX) << GAIN_FRAC_BITS;
  localparam logic [NUM_W-1:0]        NUM_LO  = NUM_W'(1) << (NUM_W - 1);

  function automatic logic signed [SUM_W-1:0] term_of(
    input smpn_op_t           op,
    input logic signed [15:0] s,
    input logic [PROD_W-1:0]  p
  );
    logic signed [SUM_W-1:0] q;
    q = $signed(SUM_W'(p[PROD_W-1:GAIN_FRAC_BITS]));
    if (op == OP_MIX) begin
      return s[15] ? -q : q;
    end
    return SUM_W'(s);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    if (v > ACC_MAX) return ACC_W'(ACC_MAX);
    if (v < ACC_MIN) return ACC_W'(ACC_MIN);
    return ACC_W'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return 16'(v);
  endfunction

  // captured item
  smpn_op_t           op_r;
  logic               last_r;
  logic signed [15:0] samp_l, samp_r;
  logic [PROD_W-1:0]  prod_l, prod_r;

  // state
  logic signed [ACC_W-1:0] left_sum, right_sum;
  logic [ACC_W-2:0]        peak_high;
  logic [ACC_W-1:0]        peak_low_mag;   // magnitude of the lowest sum
  logic [GAIN_W-1:0]       gain;
  logic [NUM_W-1:0]        cand_hi;

  logic [15:0]             mag_l, mag_r;
  logic signed [SUM_W-1:0] sum_l, sum_r;
  logic signed [ACC_W-1:0] acc_l, acc_r;
  logic [ACC_W-2:0]        hi_next;
  logic [ACC_W-1:0]        lo_next, neg_l, neg_r;
  logic [NUM_W-1:0]        gmin;
  logic [GAIN_W-1:0]       gain_new;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;

  assign mag_l = left_in[15]  ? 16'(-left_in)  : 16'(left_in);
  assign mag_r = right_in[15] ? 16'(-right_in) : 16'(right_in);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_in;
      last_r <= last_in;
      samp_l <= left_in;
      samp_r <= right_in;
      prod_l <= PROD_W'(mag_l) * PROD_W'(gain);
      prod_r <= PROD_W'(mag_r) * PROD_W'(gain);
    end
  end

  assign sum_l = SUM_W'(left_sum)  + term_of(op_r, samp_l, prod_l);
  assign sum_r = SUM_W'(right_sum) + term_of(op_r, samp_r, prod_r);
  assign acc_l = sat_acc(sum_l);
  assign acc_r = sat_acc(sum_r);
  assign neg_l = acc_l[ACC_W-1] ? ACC_W'(-acc_l) : '0;
  assign neg_r = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : '0;

  always_comb begin
    hi_next = peak_high;
    if (acc_l > $signed({1'b0, hi_next})) hi_next = acc_l[ACC_W-2:0];
    if (acc_r > $signed({1'b0, hi_next})) hi_next = acc_r[ACC_W-2:0];
    lo_next = peak_low_mag;
    if (neg_l > lo_next) lo_next = neg_l;
    if (neg_r > lo_next) lo_next = neg_r;
  end

  // smallest of unity and both quotients
  always_comb begin
    gmin = NUM_W'(UNITY);
    if (cand_hi < gmin) gmin = cand_hi;
    if (div_quo < gmin) gmin = div_quo;
    gain_new = gmin[GAIN_W-1:0];
  end

  smpn_div #(
    .NUM_W(NUM_W),
    .DEN_W(ACC_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (cmd.div_lo ? NUM_LO : NUM_HI),
    .den  (cmd.div_lo ? peak_low_mag : {1'b0, peak_high}),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum     <= '0;
      right_sum    <= '0;
      peak_high    <= '0;
      peak_low_mag <= '0;
      gain         <= UNITY;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.cand_store) cand_hi <= div_quo;
      if (cmd.exec) begin
        unique case (op_r)
          OP_MEASURE: begin
            if (last_r) begin
              peak_high    <= hi_next;
              peak_low_mag <= lo_next;
              left_sum     <= '0;
              right_sum    <= '0;
            end else begin
              left_sum  <= acc_l;
              right_sum <= acc_r;
            end
          end
          OP_MIX: begin
            if (last_r) begin
              left_sum  <= '0;
              right_sum <= '0;
              out_valid <= 1'b1;
              out_kind  <= KIND_MIX;
              out_left  <= sat16(acc_l);
              out_right <= sat16(acc_r);
              out_gain  <= gain;
              out_norm  <= ~gain[GAIN_FRAC_BITS];
            end else begin
              left_sum  <= acc_l;
              right_sum <= acc_r;
            end
          end
          OP_CLEAR: begin
            peak_high    <= '0;
            peak_low_mag <= '0;
            gain         <= UNITY;
          end
          OP_GAIN: ;
        endcase
      end
      if (cmd.gain_load) begin
        gain      <= gain_new;
        out_valid <= 1'b1;
        out_kind  <= KIND_GAIN;
        out_left  <= '0;
        out_right <= '0;
        out_gain  <= gain_new;
        out_norm  <= ~gain_new[GAIN_FRAC_BITS];
      end
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.div_done = div_done;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.gain_load) |-> !out_valid)
    else $error("result loaded over a pending result");

endmodule

/* rtl/smpn_ctrl.sv */
// Controller: sequences item execution and the two gain divisions.
module smpn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  input  smpn_pkg::smpn_op_t   op,
  input  smpn_pkg::smpn_stat_t stat,
  output logic                 s_ready,
  output smpn_pkg::smpn_cmd_t  cmd
);

  import smpn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_GAIN
  } state_t;

  state_t state;
  logic   div_start;
  logic   div_lo;
  logic   accept;

  // no item is taken while reset is held
  assign s_ready = (state == ST_IDLE) && stat.out_free && !rst;
  assign accept  = s_valid && s_ready;

  always_comb begin
    cmd            = '0;
    cmd.latch      = accept;
    cmd.exec       = (state == ST_EXEC);
    cmd.div_start  = div_start;
    cmd.div_lo     = div_lo;
    cmd.cand_store = (state == ST_DIV) && stat.div_done && !div_lo;
    cmd.gain_load  = (state == ST_GAIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
      div_lo    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (op == OP_GAIN) begin
              state     <= ST_DIV;
              div_start <= 1'b1;
              div_lo    <= 1'b0;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
        end
        ST_DIV: begin
          if (stat.div_done) begin
            if (!div_lo) begin
              div_start <= 1'b1;
              div_lo    <= 1'b1;
            end else begin
              state <= ST_GAIN;
            end
          end
        end
        ST_GAIN: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_start_in_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> state == ST_DIV)
    else $error("division launched outside divide state");

  a_gain_enters_div: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_GAIN) |=> (state == ST_DIV && cmd.div_start && !cmd.div_lo))
    else $error("gain item did not start high-peak division");

  a_exec_after_latch: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(cmd.latch))
    else $error("execute without captured item");

endmodule

/* tb/tb_stereo_mix_peak_normalizer.sv */
// Self-checking stream testbench for the stereo mix peak normalizer.
module tb_stereo_mix_peak_normalizer;
  import smpn_pkg::*;

  localparam int MAX_TRACKS     = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int OUT_W          = ((GAIN_FRAC_BITS + 34 + 7) / 8) * 8;
  localparam longint UNITY      = longint'(1) << GAIN_FRAC_BITS;
  localparam longint ACC_MAX    = longint'(MAX_TRACKS) * 32768 - 1;
  localparam longint ACC_MIN    = -longint'(MAX_TRACKS) * 32768;
  // The limit is several times the length of a gain item, which runs two serial divisions.
  localparam int IDLE_LIMIT     = 1000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 2000;

  // One frame result or gain report as the block should emit it
  typedef struct packed {
    logic                       kind;
    logic signed [15:0]         left_out;
    logic signed [15:0]         right_out;
    logic [GAIN_FRAC_BITS:0]    gain_value;
    logic                       normalized;
  } mix_result_t;

  // Mixer model plus the queue of results still owed by the block
  class mix_scoreboard;
    logic signed [20:0]      left_sum;
    logic signed [20:0]      right_sum;
    logic [19:0]             peak_high;
    logic signed [20:0]      peak_low;
    logic [GAIN_FRAC_BITS:0] gain;
    mix_result_t             owed[$];
    int                      errors;
    int                      frames;
    int                      gain_reports;

    function new();
      left_sum     = '0;
      right_sum    = '0;
      peak_high    = '0;
      peak_low     = '0;
      gain         = UNITY[GAIN_FRAC_BITS:0];
      errors       = 0;
      frames       = 0;
      gain_reports = 0;
    endfunction

    function longint clamp_acc(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return SAMPLE_MAX;
      if (v < -32768) return SAMPLE_MIN;
      return v[15:0];
    endfunction

    // sample * gain in Q16, truncated toward zero
    function longint apply_gain(logic signed [15:0] s);
      longint sv;
      longint mag;
      sv  = longint'(s);
      mag = ((sv < 0) ? -sv : sv) * longint'(gain);
      mag = mag >>> GAIN_FRAC_BITS;
      return (sv < 0) ? -mag : mag;
    endfunction

    function void owe(logic kind, logic signed [15:0] l, logic signed [15:0] r);
      mix_result_t res;
      res.kind       = kind;
      res.left_out   = l;
      res.right_out  = r;
      res.gain_value = gain;
      res.normalized = (longint'(gain) < UNITY);
      owed.push_back(res);
    endfunction

    // Update the model with one accepted item and queue whatever it emits
    function void note_item(smpn_op_t op, logic signed [15:0] l, logic signed [15:0] r,
                            logic last);
      longint ls;
      longint rs;
      longint g;
      longint cand;
      case (op)
        OP_MEASURE: begin
          ls = clamp_acc(longint'(left_sum) + longint'(l));
          rs = clamp_acc(longint'(right_sum) + longint'(r));
          if (last) begin
            if (ls > longint'(peak_high)) peak_high = ls[19:0];
            if (rs > longint'(peak_high)) peak_high = rs[19:0];
            if (ls < longint'(peak_low)) peak_low = ls[20:0];
            if (rs < longint'(peak_low)) peak_low = rs[20:0];
            ls = 0;
            rs = 0;
          end
          left_sum  = ls[20:0];
          right_sum = rs[20:0];
        end
        OP_GAIN: begin
          g = UNITY;
          // a zero peak sets no limit
          if (peak_high != 0) begin
            cand = (longint'(32767) * UNITY) / longint'(peak_high);
            if (cand < g) g = cand;
          end
          if (peak_low < 0) begin
            cand = (longint'(32768) * UNITY) / (-longint'(peak_low));
            if (cand < g) g = cand;
          end
          gain = g[GAIN_FRAC_BITS:0];
          owe(KIND_GAIN, '0, '0);
        end
        OP_MIX: begin
          ls = clamp_acc(longint'(left_sum) + apply_gain(l));
          rs = clamp_acc(longint'(right_sum) + apply_gain(r));
          if (last) begin
            owe(KIND_MIX, clamp16(ls), clamp16(rs));
            ls = 0;
            rs = 0;
          end
          left_sum  = ls[20:0];
          right_sum = rs[20:0];
        end
        default: begin
          peak_high = '0;
          peak_low  = '0;
          gain      = UNITY[GAIN_FRAC_BITS:0];
        end
      endcase
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               field, frames + gain_reports, got, want);
      errors++;
    endtask

    task check_result(mix_result_t got);
      mix_result_t want;
      if (owed.size() == 0) begin
        report("unexpected result kind", got.kind, -1);
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind) report("kind", got.kind, want.kind);
      if (got.left_out !== want.left_out) report("left_out", got.left_out, want.left_out);
      if (got.right_out !== want.right_out)
        report("right_out", got.right_out, want.right_out);
      if (got.gain_value !== want.gain_value)
        report("gain_value", got.gain_value, want.gain_value);
      if (got.normalized !== want.normalized)
        report("normalized", got.normalized, want.normalized);
      if (want.kind == KIND_GAIN) gain_reports++;
      else frames++;
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;   // left_sample[15:0], right_sample[31:16]
  logic [1:0]       s_tuser;   // operation[1:0]
  logic             s_tlast;   // last_track
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // left_out, right_out, gain_value, normalized, pad
  logic [0:0]       m_tuser;   // kind[0]

  mix_scoreboard sb;
  int            items_in;
  int            idle_cycles;
  bit            steady;       // when set, neither side inserts gaps

  stereo_mix_peak_normalizer #(
    .MAX_TRACKS    (MAX_TRACKS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  // Sample mix leaning on the extremes and on tiny values that truncate
  function automatic logic signed [15:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32767;
      1: v = -32768;
      2: v = 0;
      3: v = $urandom_range(0, 6) - 3;
      4, 5: v = $urandom_range(0, 4000) - 2000;
      default: v = $urandom();
    endcase
    return v[15:0];
  endfunction

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers update. Also runs the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result({m_tuser[0], m_tdata[15:0], m_tdata[31:16],
                         m_tdata[32 +: GAIN_FRAC_BITS + 1], m_tdata[GAIN_FRAC_BITS + 33]});
      if (s_tvalid && s_tready) begin
        sb.note_item(smpn_op_t'(s_tuser), s_tdata[15:0], s_tdata[31:16], s_tlast);
        items_in++;
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("tb_stereo_mix_peak_normalizer failed");
      $finish;
    end
  end

  // Drive one item; entered and left at a falling edge. The valid is lowered
  // only when a gap is drawn, so it never toggles twice in one step.
  task automatic send_item(smpn_op_t op, logic signed [15:0] l, logic signed [15:0] r,
                           logic last);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    s_tuser  <= op;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // One frame of track samples; now and then more tracks than the block
  // expects, so the accumulators hit their saturation limits.
  task automatic send_frame(smpn_op_t op);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_TRACKS + 1, MAX_TRACKS + 4)
                                     : $urandom_range(1, MAX_TRACKS);
    for (int i = 0; i < n; i++) send_item(op, pick_sample(), pick_sample(), i == n - 1);
  endtask

  // Result side: a fresh stall is drawn for every item.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  initial begin
    int nf;
    sb          = new();
    items_in    = 0;
    idle_cycles = 0;
    steady      = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = OP_MEASURE;
    s_tlast     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part
    send_item(OP_GAIN, 0, 0, 1'b0);            // both peaks zero: gain stays unity
    send_item(OP_MIX, 32767, -32768, 1'b1);    // extremes pass through at unity
    send_item(OP_MEASURE, 32767, -32768, 1'b0);
    send_item(OP_MEASURE, 32767, -32768, 1'b1);
    send_item(OP_GAIN, 0, 0, 1'b1);            // both peaks limit, floor of quotients
    send_item(OP_MIX, -32768, 32767, 1'b0);
    send_item(OP_MIX, -1, 1, 1'b1);            // tiny samples truncate toward zero
    send_item(OP_MEASURE, 1234, -4321, 1'b0);
    send_item(OP_GAIN, -1, -1, 1'b0);          // gain mid frame keeps partial sums
    send_item(OP_CLEAR, 16'sh5555, -16'sh5556, 1'b1); // clear mid frame as well
    send_item(OP_MIX, 1000, 1000, 1'b1);       // frame begun in measure, ended in mix
    send_item(OP_MIX, 20000, -20000, 1'b0);
    send_item(OP_MEASURE, 1000, 2000, 1'b1);   // begun in mix, ended in measure
    send_item(OP_GAIN, 0, 0, 1'b0);            // neither peak limits: gain stays unity
    send_item(OP_CLEAR, 0, 0, 1'b0);
    send_item(OP_MEASURE, -3, -7, 1'b1);
    send_item(OP_GAIN, 0, 0, 1'b0);            // only the low peak is set
    send_item(OP_MIX, 32767, 32767, 1'b0);
    send_item(OP_MIX, 32767, 32767, 1'b1);     // output saturates high
    send_item(OP_MIX, -32768, -32768, 1'b0);
    send_item(OP_MIX, -32768, -32768, 1'b1);   // output saturates low

    // Random part: mostly full measure / gain / mix passes with random
    // content, with clears and stray items of any kind mixed in.
    while (items_in < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) send_item(OP_CLEAR, pick_sample(), pick_sample(),
                                               1'($urandom_range(0, 1)));
      nf = $urandom_range(1, 5);
      repeat (nf) send_frame(OP_MEASURE);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6))
          send_item(smpn_op_t'($urandom_range(0, 3)), pick_sample(), pick_sample(),
                    1'($urandom_range(0, 1)));
      send_item(OP_GAIN, pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
      nf = $urandom_range(1, 5);
      repeat (nf) send_frame(OP_MIX);
    end
    s_tvalid <= 1'b0;

    // Drain: the watchdog ends the run if a result never shows up
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items: %0d mixed frames and %0d gain reports checked",
             items_in, sb.frames, sb.gain_reports);
    $display("%0d mismatches, %0d results still owed", sb.errors, sb.owed.size());
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("tb_stereo_mix_peak_normalizer passed");
    else
      $display("tb_stereo_mix_peak_normalizer failed");
    $finish;
  end

endmodule
